// ----- rtl/icsc_pkg.sv -----
package icsc_pkg;

  localparam logic [31:0] MagicWord = 32'h4646_4943;
  localparam logic [63:0] HeaderMin = 64'd38;
  localparam logic [7:0] Newline = 8'h0A;
  localparam logic [7:0] NullByte = 8'h00;

  typedef enum logic [2:0] {
    PH_MAGIC   = 3'd0,
    PH_FIELDS  = 3'd1,
    PH_CAPTION = 3'd2,
    PH_TAGS    = 3'd3,
    PH_PIXELS  = 3'd4,
    PH_DONE    = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    KIND_DIMS    = 3'd0,
    KIND_CAPTION = 3'd1,
    KIND_TAG     = 3'd2,
    KIND_PIXEL   = 3'd3,
    KIND_VERDICT = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    ERR_NONE        = 4'd0,
    ERR_MAGIC       = 4'd1,
    ERR_HDR_SMALL   = 4'd2,
    ERR_CONTENT_NEG = 4'd3,
    ERR_DIM_NEG     = 4'd4,
    ERR_SIZE        = 4'd5,
    ERR_EOF_FIELDS  = 4'd6,
    ERR_EOF_CAPTION = 4'd7,
    ERR_EOF_TAGS    = 4'd8,
    ERR_TAG_NEWLINE = 4'd9,
    ERR_NO_NULL     = 4'd10,
    ERR_OVERRUN     = 4'd11,
    ERR_PIXELS      = 4'd12,
    ERR_EXTRA       = 4'd13
  } err_e;

  typedef enum logic {
    ST_RUN,
    ST_MUL
  } state_e;

  typedef struct packed {
    logic        start;
    logic [62:0] width;
    logic [62:0] height;
  } mul_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] product;
  } mul_rsp_t;

endpackage

// ----- rtl/icsc_in_if.sv -----
interface icsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;

  modport source(output valid, data_byte, end_of_file, input ready);
  modport sink(input valid, data_byte, end_of_file, output ready);
endinterface

// ----- rtl/icsc_out_if.sv -----
interface icsc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [62:0] image_width;
  logic [62:0] image_height;
  logic [7:0]  text_byte;
  logic        text_end;
  logic        file_ok;
  logic [3:0]  error_code;

  modport source(output valid, kind, red, green, blue, image_width, image_height,
                 text_byte, text_end, file_ok, error_code, input ready);
  modport sink(input valid, kind, red, green, blue, image_width, image_height,
               text_byte, text_end, file_ok, error_code, output ready);
endinterface

// ----- rtl/icsc_mul.sv -----
module icsc_mul
  import icsc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  logic         busy_q, busy_d;
  logic         done_q, done_d;
  logic [127:0] acc_q, acc_d;
  logic [127:0] mcand_q, mcand_d;
  logic [62:0]  mplier_q, mplier_d;

  always_comb begin
    busy_d   = busy_q;
    done_d   = 1'b0;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    if (req_i.start) begin
      busy_d   = 1'b1;
      acc_d    = '0;
      mcand_d  = {65'd0, req_i.width} + {64'd0, req_i.width, 1'b0};
      mplier_d = req_i.height;
    end else if (busy_q) begin
      if (mplier_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        if (mplier_q[0]) begin
          acc_d = acc_q + mcand_q;
        end
        mcand_d  = {mcand_q[126:0], 1'b0};
        mplier_d = {1'b0, mplier_q[62:1]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
      acc_q    <= '0;
      mcand_q  <= '0;
      mplier_q <= '0;
    end else begin
      busy_q   <= busy_d;
      done_q   <= done_d;
      acc_q    <= acc_d;
      mcand_q  <= mcand_d;
      mplier_q <= mplier_d;
    end
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.product = acc_q;

endmodule

// ----- rtl/image_container_stream_checker_core.sv -----
// Channel | Dir | Payload
// in_i    | in  | data_byte, end_of_file
// out_o   | out | kind, red, green, blue, image_width, image_height, text_byte,
//         |     | text_end, file_ok, error_code
// Beats are taken back to back, except after the last byte of the height field.
// That byte starts the shift-add multiplier.
// The input is not ready while the multiplier runs.
// An output register holds one result; a new beat is taken when it is free or drains.
// Reset is asynchronous and returns the block to the start of a file.
module image_container_stream_checker_core
  import icsc_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  icsc_in_if.sink   in_i,
  icsc_out_if.source out_o
);

  state_e      state_q, state_d;
  phase_e      phase_q, phase_d;
  err_e        err_q, err_d;
  logic [2:0]  idx_q, idx_d;
  logic [1:0]  field_q, field_d;
  logic [63:0] asm_q, asm_d;
  logic [62:0] hsize_q, hsize_d;
  logic [62:0] csize_q, csize_d;
  logic [63:0] width_q, width_d;
  logic [62:0] height_q, height_d;
  logic [63:0] seen_q, seen_d;
  logic [63:0] pix_q, pix_d;
  logic [1:0]  mod_q, mod_d;
  logic [7:0]  red_q, red_d;
  logic [7:0]  green_q, green_d;

  logic        ov_q, ov_d;
  kind_e       okind_q, okind_d;
  logic [7:0]  ored_q, ored_d, ogreen_q, ogreen_d, oblue_q, oblue_d;
  logic [62:0] ow_q, ow_d, oh_q, oh_d;
  logic [7:0]  otext_q, otext_d;
  logic        oend_q, oend_d, ook_q, ook_d;
  err_e        ocode_q, ocode_d;

  mul_req_t    mreq;
  mul_rsp_t    mrsp;
  logic        accept;
  logic [7:0]  b;
  logic [63:0] asm_new;
  logic [63:0] seen_n;
  logic [63:0] pix_n;
  logic        emit;
  err_e        code;

  icsc_mul u_mul (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mreq),
    .rsp_o (mrsp)
  );

  assign in_i.ready = (state_q == ST_RUN) && (!ov_q || out_o.ready);
  assign accept     = in_i.valid && in_i.ready;
  assign b          = in_i.data_byte;
  assign asm_new    = {b, asm_q[63:8]};
  assign seen_n     = seen_q + 64'd1;
  assign pix_n      = pix_q + 64'd1;

  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    err_d    = err_q;
    idx_d    = idx_q;
    field_d  = field_q;
    asm_d    = asm_q;
    hsize_d  = hsize_q;
    csize_d  = csize_q;
    width_d  = width_q;
    height_d = height_q;
    seen_d   = seen_q;
    pix_d    = pix_q;
    mod_d    = mod_q;
    red_d    = red_q;
    green_d  = green_q;
    emit     = 1'b0;
    okind_d  = KIND_DIMS;
    ored_d   = '0;
    ogreen_d = '0;
    oblue_d  = '0;
    ow_d     = '0;
    oh_d     = '0;
    otext_d  = '0;
    oend_d   = 1'b0;
    ook_d    = 1'b0;
    ocode_d  = ERR_NONE;
    code     = err_q;
    mreq.start  = 1'b0;
    mreq.width  = width_q[62:0];
    mreq.height = asm_new[62:0];

    if (state_q == ST_MUL) begin
      if (mrsp.done) begin
        state_d = ST_RUN;
        if (mrsp.product[127:63] == '0 && mrsp.product[62:0] == csize_q) begin
          phase_d = PH_CAPTION;
          emit    = 1'b1;
          okind_d = KIND_DIMS;
          ow_d    = width_q[62:0];
          oh_d    = height_q;
        end else begin
          err_d = ERR_SIZE;
        end
      end
    end else if (accept && in_i.end_of_file) begin
      if (err_q == ERR_NONE) begin
        unique case (phase_q)
          PH_MAGIC:   code = ERR_MAGIC;
          PH_FIELDS:  code = ERR_EOF_FIELDS;
          PH_CAPTION: code = ERR_EOF_CAPTION;
          PH_TAGS:    code = ERR_EOF_TAGS;
          PH_PIXELS:  code = ERR_PIXELS;
          default:    code = ERR_NONE;
        endcase
      end
      emit     = 1'b1;
      okind_d  = KIND_VERDICT;
      ook_d    = (code == ERR_NONE);
      ocode_d  = code;
      phase_d  = PH_MAGIC;
      err_d    = ERR_NONE;
      idx_d    = '0;
      field_d  = '0;
      asm_d    = '0;
      hsize_d  = '0;
      csize_d  = '0;
      width_d  = '0;
      height_d = '0;
      seen_d   = '0;
      pix_d    = '0;
      mod_d    = '0;
      red_d    = '0;
      green_d  = '0;
    end else if (accept && err_q == ERR_NONE) begin
      unique case (phase_q)
        PH_MAGIC: begin
          if (b != MagicWord[{idx_q[1:0], 3'd0} +: 8]) begin
            err_d = ERR_MAGIC;
          end else begin
            seen_d = seen_n;
            if (idx_q == 3'd3) begin
              idx_d   = '0;
              asm_d   = '0;
              phase_d = PH_FIELDS;
            end else begin
              idx_d = idx_q + 3'd1;
            end
          end
        end
        PH_FIELDS: begin
          seen_d = seen_n;
          idx_d  = idx_q + 3'd1;
          asm_d  = asm_new;
          if (idx_q == 3'd7) begin
            asm_d   = '0;
            field_d = field_q + 2'd1;
            unique case (field_q)
              2'd0: begin
                hsize_d = asm_new[62:0];
                if (asm_new[63] || asm_new < HeaderMin) begin
                  err_d = ERR_HDR_SMALL;
                end
              end
              2'd1: begin
                csize_d = asm_new[62:0];
                if (asm_new[63]) begin
                  err_d = ERR_CONTENT_NEG;
                end
              end
              2'd2: width_d = asm_new;
              default: begin
                height_d = asm_new[62:0];
                if (width_q[63] || asm_new[63]) begin
                  err_d = ERR_DIM_NEG;
                end else begin
                  mreq.start = 1'b1;
                  state_d    = ST_MUL;
                end
              end
            endcase
          end
        end
        PH_CAPTION: begin
          seen_d = seen_n;
          if (seen_n > {1'b0, hsize_q}) begin
            err_d = ERR_OVERRUN;
          end else begin
            emit    = 1'b1;
            okind_d = KIND_CAPTION;
            otext_d = b;
            if (b == Newline) begin
              oend_d = 1'b1;
              if (seen_n == {1'b0, hsize_q}) begin
                phase_d = (csize_q == '0) ? PH_DONE : PH_PIXELS;
              end else begin
                phase_d = PH_TAGS;
              end
            end
          end
        end
        PH_TAGS: begin
          seen_d = seen_n;
          if (b == Newline) begin
            err_d = ERR_TAG_NEWLINE;
          end else if (seen_n == {1'b0, hsize_q} && b != NullByte) begin
            err_d = ERR_NO_NULL;
          end else begin
            emit    = 1'b1;
            okind_d = KIND_TAG;
            otext_d = b;
            oend_d  = (b == NullByte);
            if (seen_n >= {1'b0, hsize_q}) begin
              phase_d = (csize_q == '0) ? PH_DONE : PH_PIXELS;
            end
          end
        end
        PH_PIXELS: begin
          pix_d = pix_n;
          unique case (mod_q)
            2'd0: begin
              red_d = b;
              mod_d = 2'd1;
            end
            2'd1: begin
              green_d = b;
              mod_d   = 2'd2;
            end
            default: begin
              mod_d    = 2'd0;
              emit     = 1'b1;
              okind_d  = KIND_PIXEL;
              ored_d   = red_q;
              ogreen_d = green_q;
              oblue_d  = b;
              red_d    = '0;
              green_d  = '0;
              if (pix_n >= {1'b0, csize_q}) begin
                phase_d = PH_DONE;
              end
            end
          endcase
        end
        default: err_d = ERR_EXTRA;
      endcase
    end

    ov_d = emit || (ov_q && !out_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_RUN;
      phase_q  <= PH_MAGIC;
      err_q    <= ERR_NONE;
      idx_q    <= '0;
      field_q  <= '0;
      asm_q    <= '0;
      hsize_q  <= '0;
      csize_q  <= '0;
      width_q  <= '0;
      height_q <= '0;
      seen_q   <= '0;
      pix_q    <= '0;
      mod_q    <= '0;
      red_q    <= '0;
      green_q  <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      err_q    <= err_d;
      idx_q    <= idx_d;
      field_q  <= field_d;
      asm_q    <= asm_d;
      hsize_q  <= hsize_d;
      csize_q  <= csize_d;
      width_q  <= width_d;
      height_q <= height_d;
      seen_q   <= seen_d;
      pix_q    <= pix_d;
      mod_q    <= mod_d;
      red_q    <= red_d;
      green_q  <= green_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      okind_q  <= okind_d;
      ored_q   <= ored_d;
      ogreen_q <= ogreen_d;
      oblue_q  <= oblue_d;
      ow_q     <= ow_d;
      oh_q     <= oh_d;
      otext_q  <= otext_d;
      oend_q   <= oend_d;
      ook_q    <= ook_d;
      ocode_q  <= ocode_d;
    end
  end

  assign out_o.valid        = ov_q;
  assign out_o.kind         = okind_q;
  assign out_o.red          = ored_q;
  assign out_o.green        = ogreen_q;
  assign out_o.blue         = oblue_q;
  assign out_o.image_width  = ow_q;
  assign out_o.image_height = oh_q;
  assign out_o.text_byte    = otext_q;
  assign out_o.text_end     = oend_q;
  assign out_o.file_ok      = ook_q;
  assign out_o.error_code   = ocode_q;

  // The result slot is always empty while the multiplier runs.
  a_mul_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL |-> !ov_q) else $error("result slot busy during multiply");

  a_done_in_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mrsp.done |-> state_q == ST_MUL) else $error("multiplier done outside wait");

  a_err_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != ERR_NONE && !(accept && in_i.end_of_file)) |=> $stable(phase_q))
    else $error("phase moved after an error");

endmodule

// ----- bench/tb_image_container_stream_checker_core.sv -----
`timescale 1ns / 100ps

module tb_image_container_stream_checker_core;
  import icsc_pkg::*;

  localparam logic [63:0] FixedHeader = 64'd36;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned NumItems = 1150;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } beat_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [62:0] image_width;
    logic [62:0] image_height;
    logic [7:0]  text_byte;
    logic        text_end;
    logic        file_ok;
    err_e        error_code;
  } verdict_t;

  logic clk;
  logic rst_n;
  icsc_in_if in_if();
  icsc_out_if out_if();

  image_container_stream_checker_core uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  beat_t       pending_beats[$];
  verdict_t    expected_results[$];
  int unsigned mismatches = 0;
  int unsigned cyc = 0;
  logic        took = 1'b0;
  logic        hold_off = 1'b0;

  phase_e      ph;
  logic [3:0]  fidx;
  logic [63:0] acc, hdr_size, cont_size, dim_w, dim_h, hdr_seen, pix_seen;
  logic [15:0] partial;
  err_e        first_err;

  function automatic logic quiet();
    return cyc >= 1200 && cyc < 1800;
  endfunction

  task automatic clear_state();
    ph = PH_MAGIC;
    fidx = '0;
    acc = '0;
    hdr_size = '0;
    cont_size = '0;
    dim_w = '0;
    dim_h = '0;
    hdr_seen = '0;
    pix_seen = '0;
    partial = '0;
    first_err = ERR_NONE;
  endtask

  function automatic logic dims_consistent();
    logic [63:0] q;
    if (cont_size % 3 != 0) return 1'b0;
    q = cont_size / 3;
    if (dim_w == 0) return q == 0;
    if (q % dim_w != 0) return 1'b0;
    return (q / dim_w) == dim_h;
  endfunction

  task automatic after_header();
    ph = (cont_size == 0) ? PH_DONE : PH_PIXELS;
  endtask

  task automatic track_file(input beat_t bt);
    verdict_t r;
    logic [7:0] b;
    logic [1:0] fld;
    err_e code;
    logic emit;
    r = '0;
    b = bt.data_byte;
    emit = 1'b0;
    if (bt.end_of_file) begin
      code = first_err;
      if (code == ERR_NONE) begin
        case (ph)
          PH_MAGIC:   code = ERR_MAGIC;
          PH_FIELDS:  code = ERR_EOF_FIELDS;
          PH_CAPTION: code = ERR_EOF_CAPTION;
          PH_TAGS:    code = ERR_EOF_TAGS;
          PH_PIXELS:  code = ERR_PIXELS;
          default:    code = ERR_NONE;
        endcase
      end
      r.kind = KIND_VERDICT;
      r.file_ok = (code == ERR_NONE);
      r.error_code = code;
      clear_state();
      expected_results.insert(expected_results.size(), r);
      return;
    end
    if (first_err != ERR_NONE) return;
    case (ph)
      PH_MAGIC: begin
        if (b != MagicWord[8*fidx[1:0] +: 8]) begin
          first_err = ERR_MAGIC;
        end else begin
          hdr_seen++;
          fidx++;
          if (fidx >= 4) begin
            fidx = '0;
            acc = '0;
            ph = PH_FIELDS;
          end
        end
      end
      PH_FIELDS: begin
        acc |= 64'(b) << (8 * fidx[2:0]);
        fld = 2'((hdr_seen - 4) >> 3);
        hdr_seen++;
        fidx++;
        if (fidx >= 8) begin
          fidx = '0;
          case (fld)
            2'd0: begin
              hdr_size = acc;
              if (acc[63] || acc < HeaderMin) first_err = ERR_HDR_SMALL;
            end
            2'd1: begin
              cont_size = acc;
              if (acc[63]) first_err = ERR_CONTENT_NEG;
            end
            2'd2: dim_w = acc;
            default: dim_h = acc;
          endcase
          acc = '0;
          if (first_err == ERR_NONE && fld == 2'd3) begin
            if (dim_w[63] || dim_h[63]) first_err = ERR_DIM_NEG;
            else if (!dims_consistent()) first_err = ERR_SIZE;
            else begin
              ph = PH_CAPTION;
              r.kind = KIND_DIMS;
              r.image_width = dim_w[62:0];
              r.image_height = dim_h[62:0];
              emit = 1'b1;
            end
          end
        end
      end
      PH_CAPTION: begin
        hdr_seen++;
        if (hdr_seen > hdr_size) begin
          first_err = ERR_OVERRUN;
        end else begin
          r.kind = KIND_CAPTION;
          r.text_byte = b;
          emit = 1'b1;
          if (b == Newline) begin
            r.text_end = 1'b1;
            if (hdr_seen == hdr_size) after_header();
            else ph = PH_TAGS;
          end
        end
      end
      PH_TAGS: begin
        hdr_seen++;
        if (b == Newline) first_err = ERR_TAG_NEWLINE;
        else if (hdr_seen == hdr_size && b != NullByte) first_err = ERR_NO_NULL;
        else begin
          r.kind = KIND_TAG;
          r.text_byte = b;
          r.text_end = (b == NullByte);
          emit = 1'b1;
          if (hdr_seen >= hdr_size) after_header();
        end
      end
      PH_PIXELS: begin
        case (pix_seen % 3)
          0: partial = {8'h00, b};
          1: partial = {b, partial[7:0]};
          default: begin
            r.kind = KIND_PIXEL;
            r.red = partial[7:0];
            r.green = partial[15:8];
            r.blue = b;
            partial = '0;
            emit = 1'b1;
          end
        endcase
        pix_seen++;
        if (emit && pix_seen >= cont_size) ph = PH_DONE;
      end
      default: first_err = ERR_EXTRA;
    endcase
    if (emit) expected_results.insert(expected_results.size(), r);
  endtask

  task automatic add_byte(input logic [7:0] b);
    pending_beats.insert(pending_beats.size(), {b, 1'b0});
  endtask

  task automatic add_eof();
    pending_beats.insert(pending_beats.size(), {8'h00, 1'b1});
  endtask

  task automatic add_field(input logic [63:0] v);
    for (int i = 0; i < 8; i++) add_byte(v[8*i +: 8]);
  endtask

  task automatic add_header_start(input logic [63:0] hs, cs, w, h);
    for (int i = 0; i < 4; i++) add_byte(MagicWord[8*i +: 8]);
    add_field(hs);
    add_field(cs);
    add_field(w);
    add_field(h);
  endtask

  function automatic logic [7:0] text_char(input logic is_tag);
    logic [7:0] c;
    do c = 8'($urandom); while (c == Newline || (is_tag && c == NullByte));
    return c;
  endfunction

  // Builds one file, mostly well formed, sometimes damaged on purpose.
  task automatic add_file();
    logic [7:0] body[$];
    logic [63:0] hs, cs, w, h;
    int mode, cap_len, pos;
    body = {};
    mode = $urandom_range(0, 19);
    w = 64'($urandom_range(0, 4));
    h = 64'($urandom_range(0, 4));
    if (mode == 1) begin
      w = 64'h7FFF_FFFF_FFFF_FFFF;
      h = '0;
    end else if (mode == 2) begin
      w = '0;
      h = 64'h7FFF_FFFF_FFFF_FFFF;
    end
    cs = w * h * 3;
    cap_len = $urandom_range(0, 5);
    for (int i = 0; i < cap_len; i++) body.insert(body.size(), text_char(1'b0));
    body.insert(body.size(), Newline);
    for (int t = $urandom_range(0, 2); t > 0; t--) begin
      for (int i = $urandom_range(0, 3); i > 0; i--) begin
        body.insert(body.size(), text_char(1'b1));
      end
      body.insert(body.size(), NullByte);
    end
    hs = FixedHeader + 64'(body.size());
    case (mode)
      3: hs = 64'h8000_0000_0000_0026;
      4: cs = 64'hFFFF_FFFF_FFFF_FFFD;
      5: h = 64'h8000_0000_0000_0000 | h;
      6: cs = cs + 3;
      7: hs = HeaderMin;
      8: hs = hs + 1;
      default: ;
    endcase
    for (int i = 0; i < cs && i < 60; i++) body.insert(body.size(), 8'($urandom));
    if (mode == 9) body.insert(body.size(), 8'($urandom));
    if (mode == 10 && body.size() > 0) body[$urandom_range(0, body.size() - 1)] = 8'($urandom);
    add_header_start(hs, cs, w, h);
    if (mode == 11) begin
      pos = $urandom_range(0, body.size());
      while (body.size() > pos) void'(body.pop_back());
    end
    if (mode == 12) begin
      pending_beats[pending_beats.size() - $urandom_range(1, 36)] = {8'($urandom), 1'b0};
    end
    foreach (body[i]) add_byte(body[i]);
    add_eof();
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CycleLimit) begin
      $display("** image_container_stream_checker_core: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    verdict_t got, want;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        got = '{kind: kind_e'(out_if.kind), red: out_if.red, green: out_if.green,
                blue: out_if.blue, image_width: out_if.image_width,
                image_height: out_if.image_height, text_byte: out_if.text_byte,
                text_end: out_if.text_end, file_ok: out_if.file_ok,
                error_code: err_e'(out_if.error_code)};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result: %p", got);
        end else begin
          want = expected_results.pop_front();
          if (got.kind !== want.kind || got.red !== want.red || got.green !== want.green ||
              got.blue !== want.blue || got.image_width !== want.image_width ||
              got.image_height !== want.image_height || got.text_byte !== want.text_byte ||
              got.text_end !== want.text_end || got.file_ok !== want.file_ok ||
              got.error_code !== want.error_code) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
          end
        end
      end
      if (in_if.valid && in_if.ready) track_file({in_if.data_byte, in_if.end_of_file});
    end
    took <= rst_n && in_if.valid && in_if.ready;
  end

  always @(negedge clk) begin
    beat_t bt;
    if (!(in_if.valid && !took)) begin
      if (pending_beats.size() > 0 && (quiet() || $urandom_range(0, 99) >= 31)) begin
        bt = pending_beats.pop_front();
        in_if.valid <= 1'b1;
        in_if.data_byte <= bt.data_byte;
        in_if.end_of_file <= bt.end_of_file;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
    out_if.ready <= !hold_off && (quiet() || $urandom_range(0, 99) >= 31);
  end

  initial begin
    wait (cyc == 400);
    hold_off = 1'b1;
    repeat (500) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.data_byte = '0;
    in_if.end_of_file = 1'b0;
    out_if.ready = 1'b0;
    clear_state();
    rst_n = 1'b0;
    add_eof();
    add_byte(MagicWord[7:0]);
    add_byte(8'hFF);
    add_eof();
    add_byte(MagicWord[7:0]);
    add_byte(MagicWord[15:8]);
    add_byte(MagicWord[23:16]);
    add_byte(MagicWord[31:24]);
    add_byte(8'h00);
    add_eof();
    add_byte(8'h00);
    add_eof();
    while (pending_beats.size() < NumItems) add_file();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    wait (pending_beats.size() == 0 && !in_if.valid);
    wait (expected_results.size() == 0);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("** image_container_stream_checker_core: PASSED **");
    end else begin
      $display("** image_container_stream_checker_core: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/icsc_pkg.sv
rtl/icsc_in_if.sv
rtl/icsc_out_if.sv
rtl/icsc_mul.sv
rtl/image_container_stream_checker_core.sv
bench/tb_image_container_stream_checker_core.sv
